// ----- hw/rtl/u8jesc_pkg.sv -----
package u8jesc_pkg;

   // limit on the byte after a three- or four-byte lead
   typedef enum logic [2:0] {
      RULE_NONE   = 3'd0,
      RULE_MIN_A0 = 3'd1,
      RULE_MAX_9F = 3'd2,
      RULE_MIN_90 = 3'd3,
      RULE_MAX_8F = 3'd4
   } rule_type;

   typedef logic [1:0] pend_type;
   typedef logic [2:0] esc_idx_type;

   localparam logic [7:0] CONT_MASK    = 8'hc0;
   localparam logic [7:0] CONT_PATTERN = 8'h80;
   localparam logic [7:0] LEAD2_LO     = 8'hc2;
   localparam logic [7:0] LEAD2_HI     = 8'hdf;
   localparam logic [7:0] LEAD3_LO     = 8'he0;
   localparam logic [7:0] LEAD3_HI     = 8'hef;
   localparam logic [7:0] LEAD4_LO     = 8'hf0;
   localparam logic [7:0] LEAD4_HI     = 8'hf4;
   localparam logic [7:0] LEAD_E0      = 8'he0;
   localparam logic [7:0] LEAD_ED      = 8'hed;
   localparam logic [7:0] LEAD_F0      = 8'hf0;
   localparam logic [7:0] LEAD_F4      = 8'hf4;
   localparam logic [7:0] LIM_A0       = 8'ha0;
   localparam logic [7:0] LIM_9F       = 8'h9f;
   localparam logic [7:0] LIM_90       = 8'h90;
   localparam logic [7:0] LIM_8F       = 8'h8f;
   localparam logic [7:0] ASCII_MAX    = 8'h7f;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_LOW_N = 8'h6e;
   localparam logic [7:0] CH_LOW_R = 8'h72;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_LOW_U = 8'h75;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOW_A = 8'h61;

   localparam esc_idx_type LEN_PLAIN = 3'd1;
   localparam esc_idx_type LEN_SHORT = 3'd2;
   localparam esc_idx_type LEN_UHEX  = 3'd6;

   function automatic logic rule_ok(rule_type rule, logic [7:0] b);
      logic ok;
      unique case (rule)
         RULE_MIN_A0: ok = (b >= LIM_A0);
         RULE_MAX_9F: ok = (b <= LIM_9F);
         RULE_MIN_90: ok = (b >= LIM_90);
         RULE_MAX_8F: ok = (b <= LIM_8F);
         default:     ok = 1'b1;
      endcase
      return ok;
   endfunction

   // second character of a two-byte escape, zero if none
   function automatic logic [7:0] short_char(logic [7:0] b);
      logic [7:0] c;
      unique case (b)
         CH_QUOTE: c = CH_QUOTE;
         CH_BSL:   c = CH_BSL;
         CH_BS:    c = CH_LOW_B;
         CH_FF:    c = CH_LOW_F;
         CH_LF:    c = CH_LOW_N;
         CH_CR:    c = CH_LOW_R;
         CH_TAB:   c = CH_LOW_T;
         default:  c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic esc_idx_type esc_len(logic [7:0] b);
      esc_idx_type n;
      if (short_char(b) != 8'h00) begin
         n = LEN_SHORT;
      end else if (b < CH_SPACE) begin
         n = LEN_UHEX;
      end else begin
         n = LEN_PLAIN;
      end
      return n;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'h0, nib};
      end else begin
         c = CH_LOW_A + {4'h0, nib} - 8'd10;
      end
      return c;
   endfunction

   function automatic logic [7:0] esc_char(logic [7:0] b, esc_idx_type idx);
      logic [7:0]  c;
      esc_idx_type n;
      n = esc_len(b);
      if (n == LEN_PLAIN) begin
         c = b;
      end else if (idx == 3'd0) begin
         c = CH_BSL;
      end else if (n == LEN_SHORT) begin
         c = short_char(b);
      end else begin
         unique case (idx)
            3'd1:    c = CH_LOW_U;
            3'd4:    c = hex_char(b[7:4]);
            3'd5:    c = hex_char(b[3:0]);
            default: c = CH_ZERO;
         endcase
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/utf8_check_json_escape_unit.sv -----
// channel | dir | tdata (low bit up)     | tlast         | tuser (low bit up)
// req_    | in  | data_byte[7:0]         | end_of_string | -
// rsp_    | out | out_byte[7:0]          | last_of_run   | utf8_error, string_done
//
// One input byte is checked and latched per cycle while req_tready is high; its
// escape sequence (1, 2 or 6 words) is then sent from the result register, one
// word per cycle while rsp_tready is high. Plain bytes stream at one word per
// cycle if unstalled; an escape keeps req_tready low as its sequence index steps.
// A new byte is taken in the same cycle the final word of the previous one leaves.
// Synchronous active-high reset clears the UTF-8 state and empties the output.
module utf8_check_json_escape_unit
   import u8jesc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic [1:0] rsp_tuser    // [0] utf8_error, [1] string_done
);

   // UTF-8 checker state
   pend_type    pend_ff, pend_in;
   rule_type    rule_ff, rule_in;
   logic        err_ff, err_in;

   // result register
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eos_ff, eos_in;
   logic        oerr_ff, oerr_in;
   esc_idx_type idx_ff, idx_in;
   esc_idx_type len_ff, len_in;

   logic        req_fire;
   logic        rsp_final;
   logic [7:0]  b;
   pend_type    pend_c;
   rule_type    rule_c;
   logic        err_c;
   logic        cont;

   assign rsp_final  = (idx_ff == len_ff - 3'd1);
   assign req_tready = !valid_ff || (rsp_tready && rsp_final);
   assign req_fire   = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_comb begin
      pend_c = pend_ff;
      rule_c = rule_ff;
      err_c  = err_ff;
      cont   = 1'b0;
      if (pend_ff != 2'd0) begin
         if ((b & CONT_MASK) == CONT_PATTERN) begin
            cont = 1'b1;
            if (!rule_ok(rule_ff, b)) begin
               err_c = 1'b1;
            end
            rule_c = RULE_NONE;
            pend_c = pend_ff - 2'd1;
         end else begin
            // sequence cut short: drop it and treat this byte as a lead
            err_c  = 1'b1;
            pend_c = 2'd0;
            rule_c = RULE_NONE;
         end
      end
      if (!cont) begin
         rule_c = RULE_NONE;
         priority if (b <= ASCII_MAX) begin
            pend_c = 2'd0;
         end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            pend_c = 2'd1;
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            pend_c = 2'd2;
            if (b == LEAD_E0) begin
               rule_c = RULE_MIN_A0;
            end else if (b == LEAD_ED) begin
               rule_c = RULE_MAX_9F;
            end
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            pend_c = 2'd3;
            if (b == LEAD_F0) begin
               rule_c = RULE_MIN_90;
            end else if (b == LEAD_F4) begin
               rule_c = RULE_MAX_8F;
            end
         end else begin
            pend_c = 2'd0;
            err_c  = 1'b1;
         end
      end
      // truncated at end of string
      if (req_tlast && pend_c != 2'd0) begin
         err_c = 1'b1;
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      rule_in  = rule_ff;
      err_in   = err_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      eos_in   = eos_ff;
      oerr_in  = oerr_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      if (valid_ff && rsp_tready) begin
         if (rsp_final) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      if (req_fire) begin
         valid_in = 1'b1;
         byte_in  = b;
         eos_in   = req_tlast;
         oerr_in  = err_c;
         idx_in   = 3'd0;
         len_in   = esc_len(b);
         if (req_tlast) begin
            pend_in = 2'd0;
            rule_in = RULE_NONE;
            err_in  = 1'b0;
         end else begin
            pend_in = pend_c;
            rule_in = rule_c;
            err_in  = err_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 2'd0;
         rule_ff  <= RULE_NONE;
         err_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         rule_ff  <= rule_in;
         err_ff   <= err_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
      oerr_ff <= oerr_in;
      idx_ff  <= idx_in;
      len_ff  <= len_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = esc_char(byte_ff, idx_ff);
   assign rsp_tlast  = rsp_final;
   assign rsp_tuser  = {eos_ff && rsp_final, oerr_ff};

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < len_ff)
      else $error("escape index past sequence length");

   a_state_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> pend_ff == 2'd0 && rule_ff == RULE_NONE && !err_ff)
      else $error("checker state not cleared after end of string");

   a_no_take_mid_escape: assert property (@(posedge clock) disable iff (reset)
      req_tready && valid_ff |-> rsp_tready && rsp_tlast)
      else $error("input taken while escape sequence still pending");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("string_done on a word that is not last of its run");

endmodule

// ----- test/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u8jesc_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       utf8_error;
      logic       string_done;
   } esc_word_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // data_byte
   logic       req_tlast;   // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // out_byte
   logic       rsp_tlast;   // last_of_run
   logic [1:0] rsp_tuser;   // [0] utf8_error, [1] string_done

   // predicted UTF-8 tracking state
   pend_type   utf8_pend = '0;
   rule_type   utf8_rule = RULE_NONE;
   logic       utf8_err  = 1'b0;

   esc_word_type escaped_words[$];
   bit         idle_on = 1'b1;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         strings_sent = 0;
   int         words_seen = 0;
   int         strings_flagged = 0;

   utf8_check_json_escape_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Track UTF-8 state for one byte and queue its escaped words.
   function automatic void escape_and_track(logic [7:0] b, logic eos);
      logic [7:0] seq [6];
      logic [7:0] second;
      int         n;
      bit         in_limit;
      string      digits;
      esc_word_type w;
      digits = "0123456789abcdef";
      if (utf8_pend != 2'd0 && (b & CONT_MASK) == CONT_PATTERN) begin
         case (utf8_rule)
            RULE_MIN_A0: in_limit = (b >= LIM_A0);
            RULE_MAX_9F: in_limit = (b <= LIM_9F);
            RULE_MIN_90: in_limit = (b >= LIM_90);
            RULE_MAX_8F: in_limit = (b <= LIM_8F);
            default:     in_limit = 1'b1;
         endcase
         if (!in_limit) utf8_err = 1'b1;
         utf8_rule = RULE_NONE;
         utf8_pend = utf8_pend - 2'd1;
      end else begin
         // a sequence cut short: drop it and treat this byte as a lead
         if (utf8_pend != 2'd0) utf8_err = 1'b1;
         utf8_rule = RULE_NONE;
         if (b <= ASCII_MAX) begin
            utf8_pend = 2'd0;
         end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            utf8_pend = 2'd1;
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            utf8_pend = 2'd2;
            if (b == LEAD_E0) utf8_rule = RULE_MIN_A0;
            else if (b == LEAD_ED) utf8_rule = RULE_MAX_9F;
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            utf8_pend = 2'd3;
            if (b == LEAD_F0) utf8_rule = RULE_MIN_90;
            else if (b == LEAD_F4) utf8_rule = RULE_MAX_8F;
         end else begin
            utf8_pend = 2'd0;
            utf8_err  = 1'b1;
         end
      end
      if (eos && utf8_pend != 2'd0) utf8_err = 1'b1;

      case (b)
         CH_QUOTE: second = CH_QUOTE;
         CH_BSL:   second = CH_BSL;
         CH_BS:    second = "b";
         CH_FF:    second = "f";
         CH_LF:    second = "n";
         CH_CR:    second = "r";
         CH_TAB:   second = "t";
         default:  second = 8'h00;
      endcase
      if (second != 8'h00) begin
         seq[0] = CH_BSL;
         seq[1] = second;
         n = 2;
      end else if (b < CH_SPACE) begin
         seq[0] = CH_BSL;
         seq[1] = "u";
         seq[2] = "0";
         seq[3] = "0";
         seq[4] = digits[b[7:4]];
         seq[5] = digits[b[3:0]];
         n = 6;
      end else begin
         seq[0] = b;
         n = 1;
      end
      for (int k = 0; k < n; k++) begin
         w.out_byte    = seq[k];
         w.last_of_run = (k == n - 1);
         w.utf8_error  = utf8_err;
         w.string_done = (k == n - 1) && eos;
         escaped_words.insert(escaped_words.size(), w);
      end
      if (eos) begin
         utf8_pend = '0;
         utf8_rule = RULE_NONE;
         utf8_err  = 1'b0;
      end
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic eos);
      int gap;
      if (idle_on && $urandom_range(3, 0) == 0) begin
         gap = $urandom_range(12, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      escape_and_track(b, eos);
      bytes_sent++;
      if (eos) strings_sent++;
   endtask

   // Append one character: mostly well-formed, some noise and limit breaks.
   function automatic void add_char(ref logic [7:0] text[$]);
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      int         kind;
      int         len;
      lo   = 8'h80;
      hi   = 8'hbf;
      len  = 0;
      lead = 8'h00;
      kind = $urandom_range(11, 0);
      case (kind)
         0, 1, 2, 3: text.insert(text.size(), 8'($urandom_range(ASCII_MAX, 0)));
         4:          text.insert(text.size(), 8'($urandom_range(8'hff, 0)));
         5, 6: begin
            lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
            len  = 1;
         end
         7, 8: begin
            lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
            len  = 2;
            if (lead == LEAD_E0) lo = LIM_A0;
            else if (lead == LEAD_ED) hi = LIM_9F;
         end
         9, 10: begin
            lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
            len  = 3;
            if (lead == LEAD_F0) lo = LIM_90;
            else if (lead == LEAD_F4) hi = LIM_8F;
         end
         default: begin
            // limited leads with an unconstrained second byte
            case ($urandom_range(3, 0))
               0:       lead = LEAD_E0;
               1:       lead = LEAD_ED;
               2:       lead = LEAD_F0;
               default: lead = LEAD_F4;
            endcase
            len = (lead >= LEAD4_LO) ? 3 : 2;
         end
      endcase
      if (len != 0) begin
         text.insert(text.size(), lead);
         text.insert(text.size(), 8'($urandom_range(hi, lo)));
         for (int k = 1; k < len; k++)
            text.insert(text.size(), 8'($urandom_range(8'hbf, 8'h80)));
      end
   endfunction

   task automatic send_random_strings(input int n_bytes);
      logic [7:0] text[$];
      int         start;
      int         chars;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         text.delete();
         chars = $urandom_range(8, 1);
         for (int k = 0; k < chars; k++) add_char(text);
         // sometimes cut the tail to leave a sequence open
         if (text.size() > 1 && $urandom_range(5, 0) == 0) void'(text.pop_back());
         foreach (text[k]) push_byte(text[k], k == text.size() - 1);
      end
   endtask

   task automatic test_escape_set();
      push_byte(CH_QUOTE, 1'b0);
      push_byte(CH_BSL,   1'b0);
      push_byte(CH_BS,    1'b0);
      push_byte(CH_FF,    1'b0);
      push_byte(CH_LF,    1'b0);
      push_byte(CH_CR,    1'b0);
      push_byte(CH_TAB,   1'b0);
      push_byte(8'h00,    1'b0);
      push_byte(8'h1f,    1'b0);
      push_byte(8'h1b,    1'b0);
      push_byte(CH_SPACE, 1'b0);
      push_byte(8'h7f,    1'b1);
   endtask

   task automatic test_utf8_rules();
      // continuation missing: lead then plain ASCII
      push_byte(8'hc3, 1'b0);
      push_byte(8'h41, 1'b1);
      // surrogate: second byte above its limit after ED
      push_byte(8'hed, 1'b0);
      push_byte(8'ha0, 1'b0);
      push_byte(8'h80, 1'b1);
      // bad leads: one just below the two-byte leads, one at the top of the byte range
      push_byte(8'hc1, 1'b0);
      push_byte(8'hff, 1'b1);
      // string ends inside a four-byte sequence
      push_byte(8'hf0, 1'b0);
      push_byte(8'h90, 1'b0);
      push_byte(8'h80, 1'b1);
      // highest valid code point, error must be clear again
      push_byte(8'hf4, 1'b0);
      push_byte(8'h8f, 1'b0);
      push_byte(8'hbf, 1'b0);
      push_byte(8'hbf, 1'b1);
   endtask

   task automatic test_random_text();
      idle_on = 1'b1;
      send_random_strings(170);
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      send_random_strings(50);
   endtask

   initial begin : sink_drive
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(4, 0) == 0) begin
            hold = $urandom_range(12, 1) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : word_check
      esc_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (rsp_tuser[1] && rsp_tuser[0]) strings_flagged++;
         if (escaped_words.size() == 0) begin
            $error("unexpected word: out_byte 0x%02h", rsp_tdata);
            fail_count++;
         end else begin
            want = escaped_words.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", want.last_of_run, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.utf8_error) begin
               $error("utf8_error: expected %0b, got %0b", want.utf8_error, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== want.string_done) begin
               $error("string_done: expected %0b, got %0b", want.string_done, rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_escape_set();
      test_utf8_rules();
      test_random_text();
      test_full_rate();
      req_tvalid <= 1'b0;

      while (escaped_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (escaped_words.size() != 0) begin
         $error("%0d expected words never arrived", escaped_words.size());
         fail_count++;
      end
      $display("tb: %0d bytes in %0d strings sent, %0d escaped words checked",
               bytes_sent, strings_sent, words_seen);
      $display("tb: %0d strings ended with the UTF-8 error flag raised", strings_flagged);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
